[sv/ehc_pkg.sv]
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constants of the Ethernet/IPv4 header classifier.
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam logic [15:0] LINK_THRESHOLD = 16'd1500;
    localparam logic [15:0] TYPE_IPV4      = 16'd2048;
    localparam logic [15:0] TYPE_ARP       = 16'd2054;
    localparam logic [15:0] TYPE_IPV6      = 16'd34525;
    localparam logic [15:0] NET_OFFSET     = 16'd14;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_IHL        = 4'd5;

    localparam logic [2:0] CAT_OTHER_LINK  = 3'd0;
    localparam logic [2:0] CAT_ARP         = 3'd1;
    localparam logic [2:0] CAT_IPV6        = 3'd2;
    localparam logic [2:0] CAT_OTHER_NET   = 3'd3;
    localparam logic [2:0] CAT_ICMP        = 3'd4;
    localparam logic [2:0] CAT_TCP         = 3'd5;
    localparam logic [2:0] CAT_UDP         = 3'd6;
    localparam logic [2:0] CAT_OTHER_TRANS = 3'd7;

    // Raw per-frame capture, handed from the parser to the queue
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] type_word;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  flags;
        logic [3:0]  hdr_words;
        logic [7:0]  proto;
        logic [15:0] length;
    } raw_rec_t;

    // Finished classification record
    typedef struct packed {
        logic [2:0]  category;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] type_or_length;
        logic [31:0] ip_source;
        logic [31:0] ip_destination;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic        syn_seen;
        logic        fin_seen;
        logic [15:0] frame_length;
        logic        truncated;
    } res_rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

[sv/ehc_front.sv]
// ----------------------------------------------------------------------------
// ehc_front
// Byte-serial parser: tracks position and captures header fields per frame.
// ----------------------------------------------------------------------------
module ehc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        frame_byte,
    input  logic              frame_last,
    input  ehc_pkg::q_status_t q_status,
    output logic              push,
    output ehc_pkg::raw_rec_t push_rec
);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    ehc_pkg::raw_rec_t cap_reg;
    ehc_pkg::raw_rec_t cap_next;
    logic        accept;
    logic [6:0]  t_start;
    logic [15:0] t_off;
    logic        port_win;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_comb
    begin
        pos_next = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
        t_start  = 7'd14 + {1'b0, cap_reg.hdr_words, 2'b00};
        t_off    = pos_reg - {9'd0, t_start};
        port_win = (cap_reg.hdr_words >= ehc_pkg::MIN_IHL) && (pos_reg > 16'd14)
                   && (pos_reg >= {9'd0, t_start});
        cap_next = cap_reg;
        cap_next.length = pos_next;

        if (pos_reg < 16'd6)
        begin
            cap_next.dst_mac = {cap_reg.dst_mac[39:0], frame_byte};
        end
        else if (pos_reg < 16'd12)
        begin
            cap_next.src_mac = {cap_reg.src_mac[39:0], frame_byte};
        end
        else if (pos_reg < 16'd14)
        begin
            cap_next.type_word = {cap_reg.type_word[7:0], frame_byte};
        end
        else if (pos_reg == 16'd14)
        begin
            cap_next.hdr_words = (frame_byte[3:0] < ehc_pkg::MIN_IHL) ?
                                 ehc_pkg::MIN_IHL : frame_byte[3:0];
        end
        else if (pos_reg == 16'd23)
        begin
            cap_next.proto = frame_byte;
        end
        else if (pos_reg >= 16'd26 && pos_reg < 16'd30)
        begin
            cap_next.ip_src = {cap_reg.ip_src[23:0], frame_byte};
        end
        else if (pos_reg >= 16'd30 && pos_reg < 16'd34)
        begin
            cap_next.ip_dst = {cap_reg.ip_dst[23:0], frame_byte};
        end

        // transport header window, relative to the IPv4 header length
        if (port_win)
        begin
            if (t_off < 16'd2)
            begin
                cap_next.sport = {cap_reg.sport[7:0], frame_byte};
            end
            else if (t_off < 16'd4)
            begin
                cap_next.dport = {cap_reg.dport[7:0], frame_byte};
            end
            if (t_off == 16'd13)
            begin
                cap_next.flags = frame_byte[1:0];
            end
        end
    end

    assign push     = accept && frame_last;
    assign push_rec = cap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cap_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_last)
            begin
                pos_reg <= '0;
                cap_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                cap_reg <= cap_next;
            end
        end
    end

endmodule

[sv/ehc_queue.sv]
// ----------------------------------------------------------------------------
// ehc_queue
// Two-entry queue of raw frame captures between parser and classifier.
// ----------------------------------------------------------------------------
module ehc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ehc_pkg::raw_rec_t  push_rec,
    input  logic               pop,
    output ehc_pkg::raw_rec_t  head_rec,
    output ehc_pkg::q_status_t q_status
);

    ehc_pkg::raw_rec_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_status.empty = (count_reg == 2'd0);
    assign q_status.full  = (count_reg == 2'd2);
    assign head_rec       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("pop from empty queue");

endmodule

[sv/ehc_back.sv]
// ----------------------------------------------------------------------------
// ehc_back
// Classifies a queued capture, masks short fields and holds the result.
// ----------------------------------------------------------------------------
module ehc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ehc_pkg::raw_rec_t  head_rec,
    input  ehc_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output ehc_pkg::res_rec_t  res
);

    logic              valid_reg;
    ehc_pkg::res_rec_t res_reg;
    ehc_pkg::res_rec_t res_next;
    logic [15:0]       n;
    logic [15:0]       t_start;
    logic [15:0]       type_w;
    logic [7:0]        proto_w;
    logic              ipv4;

    always_comb
    begin
        n        = head_rec.length;
        t_start  = ehc_pkg::NET_OFFSET + {10'd0, head_rec.hdr_words, 2'b00};
        type_w   = (n >= 16'd14) ? head_rec.type_word : 16'd0;
        proto_w  = (n >= 16'd24) ? head_rec.proto : 8'd0;
        ipv4     = (type_w == ehc_pkg::TYPE_IPV4);
        res_next = '0;
        res_next.dst_mac        = (n >= 16'd6)  ? head_rec.dst_mac : 48'd0;
        res_next.src_mac        = (n >= 16'd12) ? head_rec.src_mac : 48'd0;
        res_next.type_or_length = type_w;
        res_next.frame_length   = n;
        res_next.truncated      = (n < 16'd14);

        if (type_w < ehc_pkg::LINK_THRESHOLD)
        begin
            res_next.category = ehc_pkg::CAT_OTHER_LINK;
        end
        else if (type_w == ehc_pkg::TYPE_ARP)
        begin
            res_next.category = ehc_pkg::CAT_ARP;
        end
        else if (type_w == ehc_pkg::TYPE_IPV6)
        begin
            res_next.category = ehc_pkg::CAT_IPV6;
        end
        else if (!ipv4)
        begin
            res_next.category = ehc_pkg::CAT_OTHER_NET;
        end
        else
        begin
            case (proto_w)
                ehc_pkg::PROTO_ICMP: res_next.category = ehc_pkg::CAT_ICMP;
                ehc_pkg::PROTO_TCP:  res_next.category = ehc_pkg::CAT_TCP;
                ehc_pkg::PROTO_UDP:  res_next.category = ehc_pkg::CAT_UDP;
                default:             res_next.category = ehc_pkg::CAT_OTHER_TRANS;
            endcase
            if (n < 16'd34)
            begin
                res_next.truncated = 1'b1;
            end
            if (n >= 16'd30)
            begin
                res_next.ip_source = head_rec.ip_src;
            end
            if (n >= 16'd34)
            begin
                res_next.ip_destination = head_rec.ip_dst;
            end
        end

        if (res_next.category == ehc_pkg::CAT_TCP || res_next.category == ehc_pkg::CAT_UDP)
        begin
            if (n >= t_start + 16'd2)
            begin
                res_next.source_port = head_rec.sport;
            end
            if (n >= t_start + 16'd4)
            begin
                res_next.destination_port = head_rec.dport;
            end
            else
            begin
                res_next.truncated = 1'b1;
            end
            if (res_next.category == ehc_pkg::CAT_TCP)
            begin
                if (n >= t_start + 16'd14)
                begin
                    res_next.syn_seen = head_rec.flags[1];
                    res_next.fin_seen = head_rec.flags[0];
                end
                else
                begin
                    res_next.truncated = 1'b1;
                end
            end
        end
    end

    assign pop       = !q_status.empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    a_flags_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.syn_seen || res_reg.fin_seen))
        |-> (res_reg.category == ehc_pkg::CAT_TCP))
        else $error("TCP flags on non-TCP record");

    a_ports_l4_only: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.source_port != 16'd0 || res_reg.destination_port != 16'd0))
        |-> (res_reg.category == ehc_pkg::CAT_TCP || res_reg.category == ehc_pkg::CAT_UDP))
        else $error("ports on non-TCP/UDP record");

    a_ip_ipv4_only: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.ip_source != 32'd0 || res_reg.ip_destination != 32'd0))
        |-> (res_reg.type_or_length == ehc_pkg::TYPE_IPV4))
        else $error("IPv4 addresses on non-IPv4 record");

endmodule

[sv/ethernet_ipv4_header_classifier.sv]
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_classifier
// Parses captured frames byte by byte and emits one header record per frame.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | frame_byte, frame_last
//  out     | out_valid / out_stall | category .. truncated (one per frame)
//
// One byte is taken every cycle while in_stall is low; the parser's position
// counter and capture registers update on each accepted byte.
// A frame's record is queued on its last byte and moves into the output register
// when that register is empty or not stalled; the two-entry queue absorbs output stalls.
// in_stall rises only when the queue holds two records.
// Reset clears the parser state, the queue pointers and out_valid.
module ethernet_ipv4_header_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  category,
    output logic [47:0] dst_mac,
    output logic [47:0] src_mac,
    output logic [15:0] type_or_length,
    output logic [31:0] ip_source,
    output logic [31:0] ip_destination,
    output logic [15:0] source_port,
    output logic [15:0] destination_port,
    output logic        syn_seen,
    output logic        fin_seen,
    output logic [15:0] frame_length,
    output logic        truncated
);

    ehc_pkg::q_status_t q_status;
    ehc_pkg::raw_rec_t  push_rec;
    ehc_pkg::raw_rec_t  head_rec;
    ehc_pkg::res_rec_t  res;
    logic               push;
    logic               pop;

    ehc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .q_status   (q_status),
        .push       (push),
        .push_rec   (push_rec)
    );

    ehc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_status (q_status)
    );

    ehc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_rec  (head_rec),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign category         = res.category;
    assign dst_mac          = res.dst_mac;
    assign src_mac          = res.src_mac;
    assign type_or_length   = res.type_or_length;
    assign ip_source        = res.ip_source;
    assign ip_destination   = res.ip_destination;
    assign source_port      = res.source_port;
    assign destination_port = res.destination_port;
    assign syn_seen         = res.syn_seen;
    assign fin_seen         = res.fin_seen;
    assign frame_length     = res.frame_length;
    assign truncated        = res.truncated;

endmodule
